@@ design/reversible_list_engine_unit_defines.svh @@
// Assertion macros for the reversible list engine.
`ifndef REVERSIBLE_LIST_ENGINE_UNIT_DEFINES_SVH
`define REVERSIBLE_LIST_ENGINE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define RLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define RLE_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) else $error(msg);
`else
`define RLE_ASSERT(lbl, prop, msg)
`define RLE_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ design/rle_pkg.sv @@
// Shared types and constants of the reversible list engine.
`timescale 1ns / 1ps
`default_nettype none
package rle_pkg;

    localparam int ITEM_W = 8;
    localparam int LINK_DEPTH = 1 << ITEM_W;
    localparam int unsigned ITEM_COUNT = 255;

    typedef enum logic [1:0] {
        CMD_POP  = 2'd0,
        CMD_JOIN = 2'd1,
        CMD_REV  = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [ITEM_W-1:0] rd_addr;
        logic [ITEM_W-1:0] wr_addr;
        logic              we_a;
        logic              we_b;
        logic [ITEM_W-1:0] wr_a;
        logic [ITEM_W-1:0] wr_b;
    } t_link_req;

endpackage
`default_nettype wire

@@ design/rle_link_mem.sv @@
// Link word memory: one read port with registered data, one write port, per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none
module rle_link_mem (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rle_pkg::t_link_req        i_req,
    output logic [rle_pkg::ITEM_W-1:0] o_q_a,
    output logic [rle_pkg::ITEM_W-1:0] o_q_b
);
    import rle_pkg::*;

    logic [ITEM_W-1:0]     r_mem_a [LINK_DEPTH];
    logic [ITEM_W-1:0]     r_mem_b [LINK_DEPTH];
    logic [LINK_DEPTH-1:0] r_vld;
    logic [ITEM_W-1:0]     r_q_a;
    logic [ITEM_W-1:0]     r_q_b;
    logic                  w_fill;

    // on the first write to an entry, fill the word not written with its own index
    assign w_fill = (i_req.we_a || i_req.we_b) && !r_vld[i_req.wr_addr];

    always_ff @(posedge i_clk) begin
        if (i_req.we_a || w_fill) begin
            r_mem_a[i_req.wr_addr] <= i_req.we_a ? i_req.wr_a : i_req.wr_addr;
        end
        if (i_req.we_b || w_fill) begin
            r_mem_b[i_req.wr_addr] <= i_req.we_b ? i_req.wr_b : i_req.wr_addr;
        end
    end

    // invalid entries read back as their own index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (i_req.we_a || i_req.we_b) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_a <= r_vld[i_req.rd_addr] ? r_mem_a[i_req.rd_addr] : i_req.rd_addr;
        r_q_b <= r_vld[i_req.rd_addr] ? r_mem_b[i_req.rd_addr] : i_req.rd_addr;
    end

    assign o_q_a = r_q_a;
    assign o_q_b = r_q_b;

endmodule
`default_nettype wire

@@ design/reversible_list_engine_unit.sv @@
// Top level of the reversible list engine: command sequencer, compare unit and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "reversible_list_engine_unit_defines.svh"
// Keeps disjoint circular lists over items 1..255, two direction-free link words per item.
// One transaction at a time; o_stall is high from accept until the command sequence ends.
// Every step waits on the link memory (one read and one write a cycle, registered read
// data). Pop, join and reverse step through their own states; a command that needs no
// link access (join with an empty or identical operand, reverse of the empty list, the
// unused code) goes straight to the final state. The result leaves through an output
// register; a stalled output only holds the sequencer in its final state. Reset restores
// every item to a list of its own through per-entry valid bits, with no clearing pass.
module reversible_list_engine_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_cmd,
    input  logic [rle_pkg::ITEM_W-1:0] i_first_tail,
    input  logic [rle_pkg::ITEM_W-1:0] i_second_tail,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [rle_pkg::ITEM_W-1:0] o_result_tail
);
    import rle_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_LD   = 13'b0000000000010,
        S_P2   = 13'b0000000000100,
        S_P3   = 13'b0000000001000,
        S_P4   = 13'b0000000010000,
        S_P5   = 13'b0000000100000,
        S_J2   = 13'b0000001000000,
        S_J3   = 13'b0000010000000,
        S_J4   = 13'b0000100000000,
        S_J5   = 13'b0001000000000,
        S_J6   = 13'b0010000000000,
        S_R2   = 13'b0100000000000,
        S_OUT  = 13'b1000000000000
    } t_state;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [ITEM_W-1:0] r_t1, n_t1;
    logic [ITEM_W-1:0] r_t2, n_t2;
    logic [ITEM_W-1:0] r_h, n_h;
    logic [ITEM_W-1:0] r_n, n_n;
    logic [ITEM_W-1:0] r_res, n_res;
    logic              r_sel, n_sel;
    logic              r_out_valid;
    logic [ITEM_W-1:0] r_out_tail;

    logic [ITEM_W-1:0] w_t1_in;
    logic [ITEM_W-1:0] w_t2_in;
    logic              w_accept;
    logic              w_out_free;
    logic [ITEM_W-1:0] w_q_a;
    logic [ITEM_W-1:0] w_q_b;
    logic [ITEM_W-1:0] w_cmp_l;
    logic [ITEM_W-1:0] w_cmp_r;
    logic              w_eq;
    logic [ITEM_W-1:0] w_next;
    t_link_req         w_req;

    assign w_t1_in    = (32'(i_first_tail) > ITEM_COUNT) ? '0 : i_first_tail;
    assign w_t2_in    = (32'(i_second_tail) > ITEM_COUNT) ? '0 : i_second_tail;
    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;

    rle_link_mem u_link_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_q_a   (w_q_a),
        .o_q_b   (w_q_b)
    );

    // shared link compare
    always_comb begin
        w_cmp_l = w_q_b;
        w_cmp_r = r_t1;
        case (r_state)
            S_LD: begin
                w_cmp_l = w_q_a;
            end
            S_P4: begin
                w_cmp_r = r_h;
            end
            S_J6: begin
                w_cmp_r = r_t2;
            end
            default: begin
            end
        endcase
    end

    assign w_eq   = (w_cmp_l == w_cmp_r);
    assign w_next = w_eq ? w_q_a : w_q_b;

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_t1    = r_t1;
        n_t2    = r_t2;
        n_h     = r_h;
        n_n     = r_n;
        n_res   = r_res;
        n_sel   = r_sel;
        w_req   = '0;
        case (r_state)
            S_IDLE: begin
                w_req.rd_addr = w_t1_in;
                if (w_accept) begin
                    n_t1    = w_t1_in;
                    n_t2    = w_t2_in;
                    n_cmd   = t_cmd'(i_cmd);
                    n_res   = w_t1_in;
                    n_state = S_OUT;
                    case (t_cmd'(i_cmd))
                        CMD_POP: begin
                            n_state = S_LD;
                        end
                        CMD_JOIN: begin
                            if (w_t1_in == '0) begin
                                n_res = w_t2_in;
                            end else if (w_t2_in != '0 && w_t2_in != w_t1_in) begin
                                n_state = S_LD;
                            end
                        end
                        CMD_REV: begin
                            if (w_t1_in != '0) begin
                                n_state = S_LD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LD: begin
                n_h = w_q_a;
                if (r_cmd == CMD_JOIN) begin
                    w_req.rd_addr = r_t2;
                    n_state       = S_J2;
                end else begin
                    w_req.rd_addr = w_q_a;
                    if (w_eq) begin
                        n_state = S_OUT;
                    end else if (r_cmd == CMD_POP) begin
                        n_state = S_P2;
                    end else begin
                        n_state = S_R2;
                    end
                end
            end
            S_P2: begin
                w_req.wr_addr = r_t1;
                w_req.wr_a    = w_next;
                w_req.we_a    = 1'b1;
                n_n           = w_next;
                n_state       = S_P3;
            end
            S_P3: begin
                w_req.rd_addr = r_n;
                n_state       = S_P4;
            end
            S_P4: begin
                w_req.wr_addr = r_n;
                w_req.wr_a    = r_t1;
                w_req.wr_b    = r_t1;
                w_req.we_a    = !w_eq;
                w_req.we_b    = w_eq;
                n_state       = S_P5;
            end
            S_P5: begin
                w_req.wr_addr = r_h;
                w_req.wr_a    = r_h;
                w_req.wr_b    = r_h;
                w_req.we_a    = 1'b1;
                w_req.we_b    = 1'b1;
                n_state       = S_OUT;
            end
            S_J2: begin
                w_req.wr_addr = r_t1;
                w_req.wr_a    = w_q_a;
                w_req.we_a    = 1'b1;
                w_req.rd_addr = r_h;
                n_n           = w_q_a;
                n_state       = S_J3;
            end
            S_J3: begin
                w_req.wr_addr = r_t2;
                w_req.wr_a    = r_h;
                w_req.we_a    = 1'b1;
                n_sel         = w_eq;
                n_state       = S_J4;
            end
            S_J4: begin
                w_req.wr_addr = r_h;
                w_req.wr_a    = r_t2;
                w_req.wr_b    = r_t2;
                w_req.we_a    = !r_sel;
                w_req.we_b    = r_sel;
                n_state       = S_J5;
            end
            S_J5: begin
                w_req.rd_addr = r_n;
                n_state       = S_J6;
            end
            S_J6: begin
                w_req.wr_addr = r_n;
                w_req.wr_a    = r_t1;
                w_req.wr_b    = r_t1;
                w_req.we_a    = !w_eq;
                w_req.we_b    = w_eq;
                n_res         = r_t2;
                n_state       = S_OUT;
            end
            S_R2: begin
                w_req.wr_addr = r_h;
                w_req.wr_a    = r_t1;
                w_req.wr_b    = w_q_a;
                w_req.we_a    = 1'b1;
                w_req.we_b    = w_eq;
                n_res         = r_h;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_t1  <= n_t1;
        r_t2  <= n_t2;
        r_h   <= n_h;
        r_n   <= n_n;
        r_res <= n_res;
        r_sel <= n_sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_out_tail <= r_res;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_result_tail = r_out_tail;

    `RLE_ASSERT(a_no_write_idle, ((r_state == S_IDLE) || (r_state == S_OUT)) |-> !(w_req.we_a || w_req.we_b), "link write outside a command sequence")
    `RLE_ASSERT_NEXT(a_accept_leaves_idle, w_accept, r_state != S_IDLE, "accepted transaction left sequencer idle")
    `RLE_ASSERT(a_result_from_out, $rose(r_out_valid) |-> ($past(r_state) == S_OUT), "result loaded outside final state")

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Self-checking bench for the reversible list engine: directed and random ops against a predictor.
`timescale 1ns / 1ps
module tb;
    import rle_pkg::*;

    localparam int RANDOM_OPS  = 530;
    localparam int MISUSE_OPS  = 20;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        t_cmd              cmd;
        logic [ITEM_W-1:0] first;
        logic [ITEM_W-1:0] second;
        logic [ITEM_W-1:0] tail;
    } t_list_op;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic [1:0]        in_cmd = CMD_NOP;
    logic [ITEM_W-1:0] in_first = '0;
    logic [ITEM_W-1:0] in_second = '0;
    logic              out_stall = 1'b0;
    logic              in_stall;
    logic              out_valid;
    logic [ITEM_W-1:0] out_tail;

    logic [ITEM_W-1:0] nbr_a [LINK_DEPTH];
    logic [ITEM_W-1:0] nbr_b [LINK_DEPTH];
    logic [ITEM_W-1:0] live_tails [$];
    t_list_op          pending_ops [$];
    logic [ITEM_W-1:0] expected_tails [$];

    int error_count = 0;
    int sent_count = 0;
    int got_count = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int stall_left = 0;

    reversible_list_engine_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_cmd         (in_cmd),
        .i_first_tail  (in_first),
        .i_second_tail (in_second),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_result_tail (out_tail)
    );

    always #2 clk = ~clk;

    function automatic logic [ITEM_W-1:0] clamp_item(logic [ITEM_W-1:0] v);
        return (v > ITEM_COUNT) ? '0 : v;
    endfunction

    function automatic logic [ITEM_W-1:0] pop_head(logic [ITEM_W-1:0] t);
        logic [ITEM_W-1:0] h;
        logic [ITEM_W-1:0] n;
        h = nbr_a[t];
        if (h == t) return t;
        nbr_a[t] = (nbr_b[h] == t) ? nbr_a[h] : nbr_b[h];
        n = nbr_a[t];
        if (nbr_b[n] == h) nbr_b[n] = t;
        else nbr_a[n] = t;
        nbr_a[h] = h;
        nbr_b[h] = h;
        return t;
    endfunction

    function automatic logic [ITEM_W-1:0] splice(logic [ITEM_W-1:0] t1, logic [ITEM_W-1:0] t2);
        logic [ITEM_W-1:0] h1;
        logic [ITEM_W-1:0] h2;
        if (t1 == 0) return t2;
        if (t2 == 0 || t2 == t1) return t1;
        h1 = nbr_a[t1];
        h2 = nbr_a[t2];
        nbr_a[t1] = h2;
        nbr_a[t2] = h1;
        if (nbr_b[h1] == t1) nbr_b[h1] = t2;
        else nbr_a[h1] = t2;
        if (nbr_b[h2] == t2) nbr_b[h2] = t1;
        else nbr_a[h2] = t1;
        return t2;
    endfunction

    function automatic logic [ITEM_W-1:0] flip(logic [ITEM_W-1:0] t);
        logic [ITEM_W-1:0] h;
        h = nbr_a[t];
        if (t == 0 || h == t) return t;
        if (nbr_b[h] == t) nbr_b[h] = nbr_a[h];
        nbr_a[h] = t;
        return h;
    endfunction

    function automatic logic [ITEM_W-1:0] predict_tail(t_cmd c, logic [ITEM_W-1:0] t1,
                                                       logic [ITEM_W-1:0] t2);
        case (c)
            CMD_POP:  return pop_head(t1);
            CMD_JOIN: return splice(t1, t2);
            CMD_REV:  return flip(t1);
            default:  return t1;
        endcase
    endfunction

    function automatic int find_live(logic [ITEM_W-1:0] t);
        if (t == 0) return -1;
        foreach (live_tails[i]) if (live_tails[i] == t) return i;
        return -1;
    endfunction

    function automatic logic [ITEM_W-1:0] any_live();
        return live_tails[$urandom_range(live_tails.size() - 1)];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // predict in queue order and keep the set of well-formed list tails current
    task automatic add_op(t_cmd c, logic [ITEM_W-1:0] t1, logic [ITEM_W-1:0] t2);
        t_list_op          op;
        logic [ITEM_W-1:0] a;
        logic [ITEM_W-1:0] b;
        logic [ITEM_W-1:0] old_head;
        int                i1;
        int                i2;
        a = clamp_item(t1);
        b = clamp_item(t2);
        i1 = find_live(a);
        i2 = find_live(b);
        old_head = nbr_a[a];
        op.cmd = c;
        op.first = t1;
        op.second = t2;
        op.tail = predict_tail(c, a, b);
        case (c)
            CMD_POP:  if (i1 >= 0 && old_head != a) live_tails.push_back(old_head);
            CMD_JOIN: if (i1 >= 0 && i2 >= 0 && i1 != i2) live_tails.delete(i1);
            CMD_REV:  if (i1 >= 0) live_tails[i1] = op.tail;
            default: ;
        endcase
        pending_ops.push_back(op);
    endtask

    task automatic add_random_op();
        logic [ITEM_W-1:0] t1;
        logic [ITEM_W-1:0] t2;
        int                r;
        r = $urandom_range(99);
        t1 = any_live();
        t2 = any_live();
        if (r < 8) begin
            case ($urandom_range(3))
                0: add_op(CMD_NOP, 8'($urandom_range(255)), 8'($urandom_range(255)));
                1: add_op(CMD_JOIN, '0, t2);
                2: add_op(CMD_JOIN, t1, t1);
                default: add_op(t_cmd'($urandom_range(2)), '0, 8'($urandom_range(255)));
            endcase
        end else if (r < 48 && live_tails.size() > 1) begin
            while (t2 == t1) t2 = any_live();
            add_op(CMD_JOIN, t1, t2);
        end else if (r < 76) begin
            add_op(CMD_POP, t1, 8'($urandom_range(255)));
        end else begin
            add_op(CMD_REV, t1, 8'($urandom_range(255)));
        end
    endtask

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // driver
    always @(posedge clk) begin
        t_list_op op;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_tails.push_back(op.tail);
                sent_count <= sent_count + 1;
            end
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    op = pending_ops.pop_front();
                    in_cmd <= op.cmd;
                    in_first <= op.first;
                    in_second <= op.second;
                    in_valid <= 1'b1;
                    send_gap <= ((sent_count % 100) < 25) ? 0 : pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        logic [ITEM_W-1:0] want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                got_count <= got_count + 1;
                if (expected_tails.size() == 0) begin
                    $error("unexpected transaction: result_tail %0d", out_tail);
                    error_count <= error_count + 1;
                end else begin
                    want = expected_tails.pop_front();
                    if (out_tail !== want) begin
                        $error("result_tail mismatch: expected %0d, actual %0d", want, out_tail);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                if ((got_count % 90) < 60 && $urandom_range(3) == 0) stall_left <= pick_gap();
            end
        end
    end

    initial begin
        for (int i = 0; i < LINK_DEPTH; i++) begin
            nbr_a[i] = i[ITEM_W-1:0];
            nbr_b[i] = i[ITEM_W-1:0];
        end
        for (int i = 1; i <= ITEM_COUNT; i++) live_tails.push_back(i[ITEM_W-1:0]);

        add_op(CMD_POP, 8'd5, 8'd0);
        add_op(CMD_REV, 8'd5, 8'd0);
        add_op(CMD_JOIN, 8'd0, 8'd7);
        add_op(CMD_JOIN, 8'd7, 8'd0);
        add_op(CMD_JOIN, 8'd7, 8'd7);
        add_op(CMD_JOIN, 8'd0, 8'd0);
        add_op(CMD_REV, 8'd0, 8'd0);
        add_op(CMD_POP, 8'd0, 8'd0);
        add_op(CMD_NOP, 8'd200, 8'd13);
        add_op(CMD_NOP, 8'd0, 8'd255);
        add_op(CMD_NOP, 8'd255, 8'd0);
        add_op(CMD_JOIN, 8'd1, 8'd255);
        add_op(CMD_JOIN, 8'd255, 8'd128);
        add_op(CMD_JOIN, 8'd128, 8'd170);
        add_op(CMD_JOIN, 8'd85, 8'd170);
        add_op(CMD_REV, 8'd170, 8'd0);
        add_op(CMD_REV, 8'd85, 8'd0);
        add_op(CMD_POP, 8'd170, 8'd0);
        add_op(CMD_POP, 8'd170, 8'd0);
        add_op(CMD_REV, 8'd170, 8'd0);
        add_op(CMD_POP, 8'd255, 8'd0);
        add_op(CMD_POP, 8'd255, 8'd0);
        add_op(CMD_POP, 8'd255, 8'd0);

        repeat (RANDOM_OPS) add_random_op();

        // random operands that need not be list tails; lists may end up malformed
        repeat (MISUSE_OPS) add_op(t_cmd'($urandom_range(3)), 8'($urandom_range(255)),
                                   8'($urandom_range(255)));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || in_valid || expected_tails.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Ran %0d transactions, %0d results: directed corner cases, %0d random list ops",
                 sent_count, got_count, RANDOM_OPS);
        $display("and %0d non-tail operand ops; %0d lists remained well formed",
                 MISUSE_OPS, live_tails.size());
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+design
design/rle_pkg.sv
design/rle_link_mem.sv
design/reversible_list_engine_unit.sv
dv/tb.sv
